// ----- hw/rtl/cbm_pkg.sv -----
`timescale 1ns / 1ps
package cbm_pkg;

    localparam int PRG_RAM_BYTES = 8192;
    localparam int MAX_PRG_BANKS = 32;
    localparam int PRG_RAM_AW    = $clog2(PRG_RAM_BYTES);
    localparam int BANK_CNT_W    = 6;

    localparam logic [BANK_CNT_W-1:0] BANK_CNT_RESET = 6'd32;
    localparam int RESET_BANKS = (32 > MAX_PRG_BANKS) ? MAX_PRG_BANKS : 32;
    localparam logic [5:0] PRG_SECOND_LAST_RESET = 6'((2 * RESET_BANKS - 2) % 64);
    localparam logic [5:0] PRG_LAST_RESET        = 6'((2 * RESET_BANKS - 1) % 64);

    localparam logic [2:0] ACT_CPU_RD = 3'd0;
    localparam logic [2:0] ACT_CPU_WR = 3'd1;
    localparam logic [2:0] ACT_PPU_RD = 3'd2;
    localparam logic [2:0] ACT_PPU_WR = 3'd3;
    localparam logic [2:0] ACT_TICK   = 3'd4;

    localparam logic [1:0] REG_BANK   = 2'd0;
    localparam logic [1:0] REG_MIRROR = 2'd1;
    localparam logic [1:0] REG_IRQ    = 2'd2;
    localparam logic [1:0] REG_ENABLE = 2'd3;

    typedef struct packed {
        logic        handled;
        logic        ram_hit;
        logic [18:0] mapped_address;
        logic        irq_active;
        logic        mirror_horizontal;
        logic        ram_rd;
    } res_t;

    typedef struct packed {
        logic                  we;
        logic                  re;
        logic [PRG_RAM_AW-1:0] addr;
        logic [7:0]            wdata;
    } ram_req_t;

    typedef struct packed {
        logic        handled;
        logic        ram_hit;
        logic [18:0] mapped_address;
        logic [7:0]  read_data;
        logic        irq_active;
        logic        mirror_horizontal;
    } out_t;

endpackage

// ----- hw/rtl/cartridge_bank_mapper_scanline_irq_top.sv -----
`timescale 1ns / 1ps
// Bank mapper with a scanline interrupt counter for a game cartridge bus.
// Each request on the input channel (in_valid, in_stall) is one bus event:
// a CPU read or write, a PPU read or write, or a scanline tick. Every request
// yields exactly one result on the output channel (out_valid, out_stall),
// in order. A request is taken when valid is high and stall is low.
// The mapper registers and bank tables update at the edge that takes the
// request; the 8 KB PRG RAM is a synchronous memory read at that same edge.
// A taken request waits in a stage register, beside the registered RAM read
// data, then moves to the result register. One request is taken every cycle
// while in_stall is low. The output holds a result register and a skid
// register, so requests keep flowing while one result waits; when the receiver
// stalls long enough both fill and in_stall rises until it takes a result.
// The bank count register (cfg_wr_en, cfg_wr_data) must be written only while
// idle, which the block does not enforce; it takes effect at the next bank-data write.
// Reset clears all mapper state, loads the reset bank tables and empties the
// pipeline; PRG RAM contents are undefined until written.
module cartridge_bank_mapper_scanline_irq_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [cbm_pkg::BANK_CNT_W-1:0] cfg_wr_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [2:0]                     action,
    input  logic [15:0]                    address,
    input  logic [7:0]                     write_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           handled,
    output logic                           ram_hit,
    output logic [18:0]                    mapped_address,
    output logic [7:0]                     read_data,
    output logic                           irq_active,
    output logic                           mirror_horizontal
);

    import cbm_pkg::*;

    logic     acc;
    res_t     res;
    ram_req_t ram_req;
    logic [7:0] ram_rdata;
    out_t     out_item;

    assign acc = in_valid && !in_stall;

    cbm_state u_state (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .acc         (acc),
        .action      (action),
        .address     (address),
        .write_data  (write_data),
        .res         (res),
        .ram_req     (ram_req)
    );

    cbm_ram #(
        .DEPTH (PRG_RAM_BYTES),
        .WIDTH (8)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .re    (ram_req.re),
        .addr  (ram_req.addr),
        .wdata (ram_req.wdata),
        .rdata (ram_rdata)
    );

    cbm_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc       (acc),
        .res       (res),
        .ram_rdata (ram_rdata),
        .out_stall (out_stall),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

    assign handled           = out_item.handled;
    assign ram_hit           = out_item.ram_hit;
    assign mapped_address    = out_item.mapped_address;
    assign read_data         = out_item.read_data;
    assign irq_active        = out_item.irq_active;
    assign mirror_horizontal = out_item.mirror_horizontal;

endmodule

// ----- hw/rtl/cbm_ram.sv -----
`timescale 1ns / 1ps
module cbm_ram #(
    parameter int DEPTH = 8192,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic             re,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/cbm_state.sv -----
`timescale 1ns / 1ps
module cbm_state (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [cbm_pkg::BANK_CNT_W-1:0]   cfg_wr_data,
    input  logic                             acc,
    input  logic [2:0]                       action,
    input  logic [15:0]                      address,
    input  logic [7:0]                       write_data,
    output cbm_pkg::res_t                    res,
    output cbm_pkg::ram_req_t                ram_req
);

    import cbm_pkg::*;

    logic [BANK_CNT_W-1:0] bank_cnt_reg;
    logic [2:0]            sel_reg, sel_next;
    logic                  swap_reg, swap_next;
    logic                  inv_reg, inv_next;
    logic [7:0]            bank_reg [8];
    logic [7:0]            bank_next [8];
    logic [5:0]            prg_tbl_reg [4];
    logic [5:0]            prg_new [4];
    logic [7:0]            chr_tbl_reg [8];
    logic [7:0]            chr_new [8];
    logic [7:0]            pair_val [4];
    logic [7:0]            single_val [4];
    logic                  mirror_reg, mirror_next;
    logic [7:0]            reload_reg, reload_next;
    logic [7:0]            count_reg, count_next;
    logic [7:0]            count_tick;
    logic                  enabled_reg, enabled_next;
    logic                  pending_reg, pending_next;

    logic                  in_ram, in_rom, in_chr, odd;
    logic                  cpu_rd_ram, cpu_rd_rom, cpu_wr_ram, ppu_rd, reg_wr, tick;
    logic                  wr_select, wr_bank;
    logic [BANK_CNT_W-1:0] banks_n;
    logic [6:0]            banks_x2;
    logic [5:0]            second_last, last;

    assign in_ram = (address[15:13] == 3'b011);
    assign in_rom = address[15];
    assign in_chr = (address[15:13] == 3'b000);
    assign odd    = address[0];

    assign cpu_rd_ram = acc && (action == ACT_CPU_RD) && in_ram;
    assign cpu_rd_rom = acc && (action == ACT_CPU_RD) && in_rom;
    assign cpu_wr_ram = acc && (action == ACT_CPU_WR) && in_ram;
    assign reg_wr     = acc && (action == ACT_CPU_WR) && in_rom;
    assign ppu_rd     = acc && (action == ACT_PPU_RD) && in_chr;
    assign tick       = acc && (action == ACT_TICK);

    assign wr_select = reg_wr && (address[14:13] == REG_BANK) && !odd;
    assign wr_bank   = reg_wr && (address[14:13] == REG_BANK) && odd;

    always_comb
    begin
        if (bank_cnt_reg == '0)
        begin
            banks_n = BANK_CNT_W'(1);
        end
        else if (bank_cnt_reg > BANK_CNT_W'(MAX_PRG_BANKS))
        begin
            banks_n = BANK_CNT_W'(MAX_PRG_BANKS);
        end
        else
        begin
            banks_n = bank_cnt_reg;
        end
    end

    assign banks_x2    = {banks_n, 1'b0};
    assign second_last = 6'(banks_x2 - 7'd2);
    assign last        = 6'(banks_x2 - 7'd1);

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            bank_next[i] = (wr_bank && (sel_reg == 3'(i))) ? write_data : bank_reg[i];
        end
    end

    always_comb
    begin
        pair_val[0]   = {bank_next[0][7:1], 1'b0};
        pair_val[1]   = {bank_next[0][7:1], 1'b1};
        pair_val[2]   = {bank_next[1][7:1], 1'b0};
        pair_val[3]   = {bank_next[1][7:1], 1'b1};
        single_val[0] = bank_next[2];
        single_val[1] = bank_next[3];
        single_val[2] = bank_next[4];
        single_val[3] = bank_next[5];
        for (int i = 0; i < 4; i++)
        begin
            chr_new[i]     = inv_reg ? single_val[i] : pair_val[i];
            chr_new[i + 4] = inv_reg ? pair_val[i] : single_val[i];
        end
        prg_new[0] = swap_reg ? second_last : bank_next[6][5:0];
        prg_new[1] = bank_next[7][5:0];
        prg_new[2] = swap_reg ? bank_next[6][5:0] : second_last;
        prg_new[3] = last;
    end

    assign count_tick = (count_reg == 8'd0) ? reload_reg : count_reg - 8'd1;

    always_comb
    begin
        sel_next     = sel_reg;
        swap_next    = swap_reg;
        inv_next     = inv_reg;
        mirror_next  = mirror_reg;
        reload_next  = reload_reg;
        count_next   = count_reg;
        enabled_next = enabled_reg;
        pending_next = pending_reg;
        if (wr_select)
        begin
            sel_next  = write_data[2:0];
            swap_next = write_data[6];
            inv_next  = write_data[7];
        end
        if (reg_wr)
        begin
            case (address[14:13])
                REG_MIRROR:
                begin
                    if (!odd)
                    begin
                        mirror_next = write_data[0];
                    end
                end
                REG_IRQ:
                begin
                    if (!odd)
                    begin
                        reload_next = write_data;
                    end
                    else
                    begin
                        count_next = 8'd0;
                    end
                end
                REG_ENABLE:
                begin
                    if (!odd)
                    begin
                        enabled_next = 1'b0;
                        pending_next = 1'b0;
                    end
                    else
                    begin
                        enabled_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (tick)
        begin
            count_next = count_tick;
            if ((count_tick == 8'd0) && enabled_reg)
            begin
                pending_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_cnt_reg <= BANK_CNT_RESET;
            sel_reg      <= '0;
            swap_reg     <= 1'b0;
            inv_reg      <= 1'b0;
            mirror_reg   <= 1'b1;
            reload_reg   <= '0;
            count_reg    <= '0;
            enabled_reg  <= 1'b0;
            pending_reg  <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                bank_reg[i]    <= '0;
                chr_tbl_reg[i] <= '0;
            end
            prg_tbl_reg[0] <= 6'd0;
            prg_tbl_reg[1] <= 6'd1;
            prg_tbl_reg[2] <= PRG_SECOND_LAST_RESET;
            prg_tbl_reg[3] <= PRG_LAST_RESET;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                bank_cnt_reg <= cfg_wr_data;
            end
            sel_reg     <= sel_next;
            swap_reg    <= swap_next;
            inv_reg     <= inv_next;
            mirror_reg  <= mirror_next;
            reload_reg  <= reload_next;
            count_reg   <= count_next;
            enabled_reg <= enabled_next;
            pending_reg <= pending_next;
            if (wr_bank)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    bank_reg[i]    <= bank_next[i];
                    chr_tbl_reg[i] <= chr_new[i];
                end
                for (int i = 0; i < 4; i++)
                begin
                    prg_tbl_reg[i] <= prg_new[i];
                end
            end
        end
    end

    always_comb
    begin
        res.handled           = cpu_rd_ram || cpu_rd_rom || cpu_wr_ram || ppu_rd;
        res.ram_hit           = cpu_rd_ram || cpu_wr_ram;
        res.irq_active        = pending_next;
        res.mirror_horizontal = mirror_next;
        res.ram_rd            = cpu_rd_ram;
        if (cpu_rd_rom)
        begin
            res.mapped_address = {prg_tbl_reg[address[14:13]], address[12:0]};
        end
        else if (ppu_rd)
        begin
            res.mapped_address = {1'b0, chr_tbl_reg[address[12:10]], address[9:0]};
        end
        else
        begin
            res.mapped_address = '0;
        end
    end

    assign ram_req.we    = cpu_wr_ram;
    assign ram_req.re    = cpu_rd_ram;
    assign ram_req.addr  = PRG_RAM_AW'(address[12:0]);
    assign ram_req.wdata = write_data;

endmodule

// ----- hw/rtl/cbm_outq.sv -----
`timescale 1ns / 1ps
module cbm_outq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          acc,
    input  cbm_pkg::res_t res,
    input  logic [7:0]    ram_rdata,
    input  logic          out_stall,
    output logic          in_stall,
    output logic          out_valid,
    output cbm_pkg::out_t out_item
);

    import cbm_pkg::*;

    logic  s1_valid_reg, s1_valid_next;
    res_t  s1_res_reg;
    logic  head_valid_reg, head_valid_next;
    out_t  head_reg, head_next;
    logic  skid_valid_reg, skid_valid_next;
    out_t  skid_reg, skid_next;
    out_t  s1_item;
    logic  pop, push;

    assign pop      = head_valid_reg && !out_stall;
    assign push     = s1_valid_reg && (!skid_valid_reg || pop);
    assign in_stall = s1_valid_reg && !push;

    always_comb
    begin
        s1_item.handled           = s1_res_reg.handled;
        s1_item.ram_hit           = s1_res_reg.ram_hit;
        s1_item.mapped_address    = s1_res_reg.mapped_address;
        s1_item.read_data         = s1_res_reg.ram_rd ? ram_rdata : 8'd0;
        s1_item.irq_active        = s1_res_reg.irq_active;
        s1_item.mirror_horizontal = s1_res_reg.mirror_horizontal;
    end

    always_comb
    begin
        head_valid_next = head_valid_reg;
        head_next       = head_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                head_next       = skid_reg;
                skid_valid_next = push;
                skid_next       = s1_item;
            end
            else
            begin
                head_valid_next = push;
                head_next       = s1_item;
            end
        end
        else if (push)
        begin
            if (head_valid_reg)
            begin
                skid_valid_next = 1'b1;
                skid_next       = s1_item;
            end
            else
            begin
                head_valid_next = 1'b1;
                head_next       = s1_item;
            end
        end
        if (acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (push)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_res_reg <= res;
        end
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign out_valid = head_valid_reg;
    assign out_item  = head_reg;

endmodule

// ----- hw/rtl/cbm_checker.sv -----
`timescale 1ns / 1ps
module cbm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        handled,
    input logic        ram_hit,
    input logic [18:0] mapped_address,
    input logic [7:0]  read_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(mapped_address) && $stable(read_data))
        else $error("Stalled result changed or was dropped.");

    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("Input stalled while the output side was empty.");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid |=> ##1 out_valid)
        else $error("Result did not appear two cycles after its request.");

    a_ram_claimed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ram_hit |-> handled && (mapped_address == 19'd0))
        else $error("PRG RAM result is not claimed or carries a ROM offset.");

endmodule

bind cartridge_bank_mapper_scanline_irq_top cbm_checker u_cbm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .handled        (handled),
    .ram_hit        (ram_hit),
    .mapped_address (mapped_address),
    .read_data      (read_data)
);
